### hdl/grf_pkg.sv
// Shared constants and types for the Gaussian row filter.
package grf_pkg;

    localparam int GRF_MAX_RADIUS = 15;
    localparam int GRF_CHANNELS   = 4;
    localparam int GRF_CH_W       = 8;
    localparam int GRF_PX_W       = GRF_CHANNELS * GRF_CH_W;
    localparam int GRF_TAP_W      = 16;
    localparam int GRF_IDX_W      = 5;
    localparam int GRF_RADIUS_W   = 4;
    localparam int GRF_Q_SHIFT    = 8;
    localparam int GRF_CNT_W      = 5;

    localparam logic [GRF_CNT_W-1:0] GRF_CNT_MAX = 5'd31;

    localparam logic OPC_LOAD_TAP = 1'b0;
    localparam logic OPC_PIXEL    = 1'b1;

    typedef struct packed {
        logic fill;
        logic shift;
    } grf_win_ctrl_t;

endpackage

### hdl/grf_cell.sv
// One pixel cell of the window chain.
module grf_cell
    import grf_pkg::*;
(
    input  logic                clk,
    input  grf_win_ctrl_t       ctrl,
    input  logic [GRF_PX_W-1:0] fill_px,
    input  logic [GRF_PX_W-1:0] prev_px,
    output logic [GRF_PX_W-1:0] px
);

    logic [GRF_PX_W-1:0] px_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.fill)
        begin
            px_reg <= fill_px;
        end
        else if (ctrl.shift)
        begin
            px_reg <= prev_px;
        end
    end

    assign px = px_reg;

endmodule

### hdl/grf_mac.sv
// Multiply-accumulate lane for one channel with rounding and saturation.
module grf_mac
    import grf_pkg::*;
#(
    parameter int DEPTH = 2 * GRF_MAX_RADIUS + 1
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic                        first,
    input  logic signed [GRF_TAP_W-1:0] tap,
    input  logic [GRF_CH_W-1:0]         px,
    output logic [GRF_CH_W-1:0]         result
);

    localparam int PROD_W = GRF_TAP_W + GRF_CH_W + 1;
    localparam int ACC_W  = GRF_TAP_W + GRF_CH_W + $clog2(DEPTH);
    localparam int Q_W    = ACC_W + 1 - GRF_Q_SHIFT;

    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]         prod_ext;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W:0]           rnd;
    logic [Q_W-1:0]           q;

    assign prod     = tap * $signed({1'b0, px});
    assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

    always_comb
    begin
        if (first)
        begin
            acc_next = prod_ext;
        end
        else
        begin
            acc_next = acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
        end
    end

    // The bias makes the arithmetic shift round to nearest.
    assign rnd = {acc_reg[ACC_W-1], acc_reg}
               + (ACC_W + 1)'(1 << (GRF_Q_SHIFT - 1));
    assign q   = rnd[ACC_W:GRF_Q_SHIFT];

    always_comb
    begin
        if (q[Q_W-1])
        begin
            result = '0;
        end
        else if (|q[Q_W-2:GRF_CH_W])
        begin
            result = '1;
        end
        else
        begin
            result = q[GRF_CH_W-1:0];
        end
    end

endmodule

### hdl/gaussian_row_filter_rgba.sv
// Top level of the horizontal Gaussian row filter over RGBA pixels.
// A pixel with a result runs a MAC pass over 2r+1 taps (r = radius), then the emit state.
// Input stalls during both; a tap load or a pixel without a result leaves the block idle.
// A row end then runs r more window shifts, each followed by a MAC pass and emit when a result is due.
// A stalled output register holds the block in its emit cycle until the register is free.
// Reset clears the taps, the radius, the pixel count and the output valid.
module gaussian_row_filter_rgba
    import grf_pkg::*;
#(
    parameter int MAX_RADIUS = GRF_MAX_RADIUS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic [GRF_RADIUS_W-1:0]     cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        opcode,
    input  logic [GRF_IDX_W-1:0]        tap_index,
    input  logic signed [GRF_TAP_W-1:0] tap_value,
    input  logic [GRF_CH_W-1:0]         red_in,
    input  logic [GRF_CH_W-1:0]         green_in,
    input  logic [GRF_CH_W-1:0]         blue_in,
    input  logic [GRF_CH_W-1:0]         alpha_in,
    input  logic                        row_end,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [GRF_CH_W-1:0]         red_out,
    output logic [GRF_CH_W-1:0]         green_out,
    output logic [GRF_CH_W-1:0]         blue_out,
    output logic [GRF_CH_W-1:0]         alpha_out,
    output logic                        row_done,
    output logic                        run_last
);

    localparam int DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int WIN_AW = $clog2(DEPTH);
    localparam int CMP_W  = GRF_CNT_W + WIN_AW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_MAC,
        ST_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [GRF_RADIUS_W-1:0]     radius_reg;
    logic [GRF_CNT_W-1:0]        cnt_reg, cnt_next;
    logic                        fresh_reg, fresh_next;
    logic                        flush_reg, flush_next;
    logic [WIN_AW-1:0]           step_reg, step_next;
    logic [WIN_AW-1:0]           idx_reg, idx_next;
    logic signed [GRF_TAP_W-1:0] taps_reg [DEPTH];
    logic                        tap_we;
    logic                        out_valid_reg, out_valid_next;
    logic                        row_done_reg, row_done_next;
    logic                        run_last_reg, run_last_next;
    logic [GRF_PX_W-1:0]         out_px_reg;
    logic                        out_load;

    logic                        in_accept;
    logic                        out_free;
    logic [WIN_AW-1:0]           eff_r;
    logic [WIN_AW-1:0]           span;
    logic [WIN_AW-1:0]           rd_idx;
    logic [GRF_CNT_W-1:0]        cnt_inc;
    logic [WIN_AW-1:0]           step_inc;
    logic                        last_step;
    logic [GRF_PX_W-1:0]         pix_in;
    logic [GRF_PX_W-1:0]         shift_src;
    logic [GRF_PX_W-1:0]         win_px [DEPTH];
    logic [GRF_PX_W-1:0]         mac_px;
    logic [GRF_PX_W-1:0]         mac_res;
    grf_win_ctrl_t               win_ctrl;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pix_in    = {alpha_in, blue_in, green_in, red_in};

    always_comb
    begin
        if (int'(radius_reg) > MAX_RADIUS)
        begin
            eff_r = WIN_AW'(MAX_RADIUS);
        end
        else
        begin
            eff_r = WIN_AW'(radius_reg);
        end
    end

    assign span      = eff_r << 1;
    assign rd_idx    = span - idx_reg;
    assign cnt_inc   = fresh_reg ? GRF_CNT_W'(1)
                     : ((cnt_reg == GRF_CNT_MAX) ? cnt_reg : cnt_reg + 1'b1);
    assign step_inc  = step_reg + 1'b1;
    assign last_step = (step_reg == eff_r);

    assign win_ctrl.fill  = in_accept && (opcode == OPC_PIXEL) && fresh_reg;
    assign win_ctrl.shift = (in_accept && (opcode == OPC_PIXEL) && !fresh_reg)
                          || (state_reg == ST_SHIFT);
    assign shift_src      = (state_reg == ST_SHIFT) ? win_px[0] : pix_in;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            grf_cell u_cell (
                .clk     (clk),
                .ctrl    (win_ctrl),
                .fill_px (pix_in),
                .prev_px ((k == 0) ? shift_src : win_px[(k == 0) ? 0 : k - 1]),
                .px      (win_px[k])
            );
        end
    endgenerate

    assign mac_px = win_px[rd_idx];

    genvar c;
    generate
        for (c = 0; c < GRF_CHANNELS; c++)
        begin : g_lane
            grf_mac #(
                .DEPTH (DEPTH)
            ) u_mac (
                .clk    (clk),
                .en     (state_reg == ST_MAC),
                .first  (idx_reg == '0),
                .tap    (taps_reg[idx_reg]),
                .px     (mac_px[c*GRF_CH_W +: GRF_CH_W]),
                .result (mac_res[c*GRF_CH_W +: GRF_CH_W])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        fresh_next     = fresh_reg;
        flush_next     = flush_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        tap_we         = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        row_done_next  = row_done_reg;
        run_last_next  = run_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (opcode == OPC_LOAD_TAP)
                    begin
                        tap_we = (int'(tap_index) < DEPTH);
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        fresh_next = 1'b0;
                        flush_next = row_end;
                        step_next  = '0;
                        idx_next   = '0;
                        if (CMP_W'(cnt_inc) > CMP_W'(eff_r))
                        begin
                            state_next = ST_MAC;
                        end
                        else if (row_end)
                        begin
                            state_next = ST_SHIFT;
                        end
                    end
                end
            end
            ST_SHIFT:
            begin
                step_next = step_inc;
                idx_next  = '0;
                if ((CMP_W'(cnt_reg) + CMP_W'(step_inc)) > CMP_W'(eff_r))
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (idx_reg == span)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    row_done_next  = flush_reg && last_step;
                    run_last_next  = !flush_reg || last_step;
                    if (flush_reg && !last_step)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        if (flush_reg)
                        begin
                            cnt_next   = '0;
                            fresh_next = 1'b1;
                            flush_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radius_reg    <= '0;
            cnt_reg       <= '0;
            fresh_reg     <= 1'b1;
            flush_reg     <= 1'b0;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            row_done_reg  <= 1'b0;
            run_last_reg  <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                taps_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fresh_reg     <= fresh_next;
            flush_reg     <= flush_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            row_done_reg  <= row_done_next;
            run_last_reg  <= run_last_next;
            if (cfg_wen)
            begin
                radius_reg <= cfg_wdata;
            end
            if (tap_we)
            begin
                taps_reg[WIN_AW'(tap_index)] <= tap_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_px_reg <= mac_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_done  = row_done_reg;
    assign run_last  = run_last_reg;
    assign red_out   = out_px_reg[0*GRF_CH_W +: GRF_CH_W];
    assign green_out = out_px_reg[1*GRF_CH_W +: GRF_CH_W];
    assign blue_out  = out_px_reg[2*GRF_CH_W +: GRF_CH_W];
    assign alpha_out = out_px_reg[3*GRF_CH_W +: GRF_CH_W];

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_row_filter_rgba: random RGBA rows against a predictor.
module tb_top;
    import grf_pkg::*;

    localparam int DEPTH        = 2 * GRF_MAX_RADIUS + 1;
    localparam int DRAIN_CYCLES = 2 * GRF_MAX_RADIUS + 10;
    localparam int MAX_WAIT     = 17;
    localparam int PHASES       = 12;

    typedef struct packed {
        logic                        opc;
        logic [GRF_IDX_W-1:0]        idx;
        logic signed [GRF_TAP_W-1:0] weight;
        logic [GRF_PX_W-1:0]         pixel;
        logic                        last_px;
    } filter_cmd_t;

    typedef struct packed {
        logic [GRF_PX_W-1:0] pixel;
        logic                row_done;
        logic                run_last;
    } out_px_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_wen   = 1'b0;
    logic [GRF_RADIUS_W-1:0]     cfg_wdata = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic                        opcode    = OPC_LOAD_TAP;
    logic [GRF_IDX_W-1:0]        tap_index = '0;
    logic signed [GRF_TAP_W-1:0] tap_value = '0;
    logic [GRF_CH_W-1:0]         red_in    = '0;
    logic [GRF_CH_W-1:0]         green_in  = '0;
    logic [GRF_CH_W-1:0]         blue_in   = '0;
    logic [GRF_CH_W-1:0]         alpha_in  = '0;
    logic                        row_end   = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [GRF_CH_W-1:0]         red_out;
    logic [GRF_CH_W-1:0]         green_out;
    logic [GRF_CH_W-1:0]         blue_out;
    logic [GRF_CH_W-1:0]         alpha_out;
    logic                        row_done;
    logic                        run_last;

    filter_cmd_t cmd_queue [$];
    out_px_t     expected_px [$];
    filter_cmd_t cur_cmd;
    int          send_gap;
    int          stall_left;
    bit          sent_now;
    bit          quiet;
    int          mismatches;
    int          results_seen;

    logic signed [GRF_TAP_W-1:0] model_taps [DEPTH];
    logic [GRF_PX_W-1:0]         model_win [DEPTH];
    int unsigned                 model_seen;
    bit                          model_fresh;
    int unsigned                 model_radius;

    gaussian_row_filter_rgba dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .tap_index (tap_index),
        .tap_value (tap_value),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .row_end   (row_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out),
        .row_done  (row_done),
        .run_last  (run_last)
    );

    always #5 clk = ~clk;

    function automatic int draw_wait();
        if (quiet || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [GRF_CH_W-1:0] blur_channel(int ch);
        longint      acc;
        longint      v;
        int unsigned i;
        acc = 0;
        for (i = 0; i <= 2 * model_radius; i++)
            acc += longint'(model_taps[i])
                 * longint'(model_win[2 * model_radius - i][GRF_CH_W * ch +: GRF_CH_W]);
        v = (acc + 128) >>> GRF_Q_SHIFT;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[GRF_CH_W-1:0];
    endfunction

    function automatic out_px_t blurred_pixel(logic done, logic last);
        out_px_t res;
        res.pixel    = {blur_channel(3), blur_channel(2), blur_channel(1), blur_channel(0)};
        res.row_done = done;
        res.run_last = last;
        return res;
    endfunction

    task automatic shift_window(logic [GRF_PX_W-1:0] px);
        int i;
        for (i = DEPTH - 1; i > 0; i--)
            model_win[i] = model_win[i-1];
        model_win[0] = px;
    endtask

    task automatic apply_cmd(filter_cmd_t c);
        int unsigned r;
        int unsigned n;
        int unsigned t;
        int          i;
        r = model_radius;
        if (c.opc == OPC_LOAD_TAP)
        begin
            if (c.idx < DEPTH)
                model_taps[c.idx] = c.weight;
        end
        else
        begin
            if (model_fresh)
            begin
                for (i = 0; i < DEPTH; i++)
                    model_win[i] = c.pixel;
                model_seen  = 1;
                model_fresh = 1'b0;
            end
            else
            begin
                shift_window(c.pixel);
                if (model_seen < 31)
                    model_seen++;
            end
            n = model_seen;
            if (!c.last_px)
            begin
                if (n > r)
                    expected_px.push_back(blurred_pixel(1'b0, 1'b1));
            end
            else
            begin
                for (t = 0; t <= r; t++)
                begin
                    if (t > 0)
                        shift_window(c.pixel);
                    if (n + t > r)
                        expected_px.push_back(blurred_pixel(t == r, t == r));
                end
                model_seen  = 0;
                model_fresh = 1'b1;
            end
        end
    endtask

    task automatic note_mismatch(string msg);
        $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic push_tap(int idx, int weight);
        filter_cmd_t c;
        c.opc     = OPC_LOAD_TAP;
        c.idx     = GRF_IDX_W'(idx);
        c.weight  = GRF_TAP_W'(weight);
        c.pixel   = $urandom;
        c.last_px = 1'($urandom_range(0, 1));
        cmd_queue.push_back(c);
    endtask

    task automatic push_pixel(logic [GRF_PX_W-1:0] px, logic last);
        filter_cmd_t c;
        c.opc     = OPC_PIXEL;
        c.idx     = GRF_IDX_W'($urandom);
        c.weight  = GRF_TAP_W'($urandom);
        c.pixel   = px;
        c.last_px = last;
        cmd_queue.push_back(c);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (cmd_queue.size() != 0 || in_valid || expected_px.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_radius(int unsigned r);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= GRF_RADIUS_W'(r);
        @(posedge clk);
        cfg_wen      <= 1'b0;
        model_radius = r;
        @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            sent_now = in_valid && !in_stall;
            if (sent_now)
            begin
                apply_cmd(cur_cmd);
                send_gap = draw_wait();
            end
            if (!in_valid || sent_now)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    cur_cmd = cmd_queue.pop_front();
                    opcode    <= cur_cmd.opc;
                    tap_index <= cur_cmd.idx;
                    tap_value <= cur_cmd.weight;
                    red_in    <= cur_cmd.pixel[7:0];
                    green_in  <= cur_cmd.pixel[15:8];
                    blue_in   <= cur_cmd.pixel[23:16];
                    alpha_in  <= cur_cmd.pixel[31:24];
                    row_end   <= cur_cmd.last_px;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                out_px_t want;
                results_seen++;
                if (expected_px.size() == 0)
                begin
                    note_mismatch("result with no expected value");
                end
                else
                begin
                    want = expected_px.pop_front();
                    if (red_out !== want.pixel[7:0])
                        note_mismatch($sformatf("red_out %0d, expected %0d",
                                                red_out, want.pixel[7:0]));
                    if (green_out !== want.pixel[15:8])
                        note_mismatch($sformatf("green_out %0d, expected %0d",
                                                green_out, want.pixel[15:8]));
                    if (blue_out !== want.pixel[23:16])
                        note_mismatch($sformatf("blue_out %0d, expected %0d",
                                                blue_out, want.pixel[23:16]));
                    if (alpha_out !== want.pixel[31:24])
                        note_mismatch($sformatf("alpha_out %0d, expected %0d",
                                                alpha_out, want.pixel[31:24]));
                    if (row_done !== want.row_done)
                        note_mismatch($sformatf("row_done %b, expected %b",
                                                row_done, want.row_done));
                    if (run_last !== want.run_last)
                        note_mismatch($sformatf("run_last %b, expected %b",
                                                run_last, want.run_last));
                end
                stall_left = draw_wait();
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #(20_000_000);
        $display("[gaussian_row_filter_rgba] ERROR");
        $finish;
    end

    initial
    begin
        int          phase;
        int unsigned r;
        int          budget;
        int          pushed;
        int          row_len;
        int          k;
        int          i;
        int          mode;
        for (i = 0; i < DEPTH; i++)
        begin
            model_taps[i] = '0;
            model_win[i]  = '0;
        end
        model_seen   = 0;
        model_fresh  = 1'b1;
        model_radius = 0;
        mismatches   = 0;
        results_seen = 0;
        quiet        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset state: zero taps and radius zero give a black pixel.
        push_pixel(32'hFFFFFFFF, 1'b1);
        wait_idle();

        set_radius(1);
        push_tap(0, 64);
        push_tap(1, 128);
        push_tap(2, 64);
        push_tap(31, -32768);
        push_tap(30, 32767);
        push_pixel(32'h00000000, 1'b0);
        push_pixel(32'hFFFFFFFF, 1'b0);
        push_pixel(32'h12345678, 1'b1);
        push_pixel(32'hA5C3F00F, 1'b1);
        push_pixel(32'h80808080, 1'b0);
        push_pixel(32'h7F017F01, 1'b1);
        wait_idle();

        set_radius(0);
        push_tap(0, 32767);
        push_pixel(32'h01FF0080, 1'b0);
        push_tap(0, -32768);
        push_pixel(32'hFFFFFFFF, 1'b0);
        push_tap(0, 128);
        push_pixel(32'h03020100, 1'b0);
        push_tap(0, 256);
        push_pixel(32'h80402010, 1'b1);
        wait_idle();

        set_radius(15);
        push_pixel(32'hFF00FF00, 1'b0);
        push_pixel(32'h00FF00FF, 1'b1);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++)
        begin
            quiet = (phase % 4 == 1);
            if (phase == 0)
                r = 0;
            else if (phase == 1 || phase == PHASES - 1)
                r = 15;
            else if ($urandom_range(0, 3) == 0)
                r = $urandom_range(5, 14);
            else
                r = $urandom_range(1, 4);
            set_radius(r);
            mode = $urandom_range(0, 2);
            for (i = 0; i <= 2 * r; i++)
            begin
                if (mode == 0)
                    push_tap(i, $urandom);
                else
                    push_tap(i, int'($urandom_range(0, 600 / (2 * r + 1))) - 8);
            end
            budget = (r == 15) ? 12 : 18;
            pushed = 0;
            while (pushed < budget)
            begin
                if ($urandom_range(0, 9) == 0)
                    row_len = $urandom_range(30, 36);
                else
                    row_len = $urandom_range(1, 2 * r + 4);
                for (k = 0; k < row_len; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        push_tap($urandom_range(0, 31), $urandom);
                        pushed++;
                    end
                    push_pixel($urandom, k == row_len - 1 && $urandom_range(0, 7) != 0);
                    pushed++;
                end
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("[gaussian_row_filter_rgba] OK");
        else
            $display("[gaussian_row_filter_rgba] ERROR");
        $finish;
    end

endmodule

### files.f
hdl/grf_pkg.sv
hdl/grf_cell.sv
hdl/grf_mac.sv
hdl/gaussian_row_filter_rgba.sv
verif/tb_top.sv
